### sv/csr_pkg.sv
// Shared types and constants for the row-pair cosine similarity block.
`default_nettype none
package csr_pkg;

    localparam int ELEM_W  = 16;
    localparam int DOT_W   = 42;
    localparam int NORM_W  = 41;
    localparam int COS_W   = 16;
    localparam int PROD_W  = 2 * NORM_W;
    localparam int NUM_W   = NORM_W + COS_W - 1;
    localparam int EPS_W   = 64;

    // Accumulator clamp value, 2^40.
    localparam logic [NORM_W-1:0] ACC_LIM = {1'b1, {(NORM_W-1){1'b0}}};

    // One finished row: the three saturated sums.
    typedef struct packed {
        logic signed [DOT_W-1:0] dot_xy;
        logic [NORM_W-1:0]       norm_xx;
        logic [NORM_W-1:0]       norm_yy;
    } row_sums_t;

endpackage
`default_nettype wire

### sv/csr_front.sv
// Front end: accepts element pairs and keeps the saturating row sums.
`default_nettype none
module csr_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [csr_pkg::ELEM_W-1:0] x_elem,
    input  wire logic signed [csr_pkg::ELEM_W-1:0] y_elem,
    input  wire logic                  last_elem,
    input  wire logic                  q_full,
    output logic                       q_push,
    output csr_pkg::row_sums_t         q_data
);
    localparam int PW = 2 * csr_pkg::ELEM_W;

    logic signed [csr_pkg::DOT_W-1:0] cross_reg, cross_next;
    logic [csr_pkg::NORM_W-1:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic signed [PW-1:0]             pxy, pxx, pyy;
    logic signed [csr_pkg::DOT_W:0]   sum_c;
    logic [csr_pkg::NORM_W:0]         sum_x, sum_y;
    logic signed [csr_pkg::DOT_W:0]   lim_p, lim_n;
    logic                             take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_comb begin
        pxy   = x_elem * y_elem;
        pxx   = x_elem * x_elem;
        pyy   = y_elem * y_elem;
        lim_p = $signed({2'b00, csr_pkg::ACC_LIM});
        lim_n = -lim_p;
        sum_c = $signed({cross_reg[csr_pkg::DOT_W-1], cross_reg})
              + $signed({{(csr_pkg::DOT_W+1-PW){pxy[PW-1]}}, pxy});
        sum_x = {1'b0, sx_reg} + {{(csr_pkg::NORM_W+1-PW){1'b0}}, pxx};
        sum_y = {1'b0, sy_reg} + {{(csr_pkg::NORM_W+1-PW){1'b0}}, pyy};

        if (sum_c > lim_p) begin
            cross_next = lim_p[csr_pkg::DOT_W-1:0];
        end else if (sum_c < lim_n) begin
            cross_next = lim_n[csr_pkg::DOT_W-1:0];
        end else begin
            cross_next = sum_c[csr_pkg::DOT_W-1:0];
        end
        sx_next = (sum_x > {1'b0, csr_pkg::ACC_LIM}) ? csr_pkg::ACC_LIM
                                                      : sum_x[csr_pkg::NORM_W-1:0];
        sy_next = (sum_y > {1'b0, csr_pkg::ACC_LIM}) ? csr_pkg::ACC_LIM
                                                      : sum_y[csr_pkg::NORM_W-1:0];

        q_push         = take && last_elem;
        q_data.dot_xy  = cross_next;
        q_data.norm_xx = sx_next;
        q_data.norm_yy = sy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cross_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
        end else if (take) begin
            if (last_elem) begin
                cross_reg <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
            end else begin
                cross_reg <= cross_next;
                sx_reg    <= sx_next;
                sy_reg    <= sy_next;
            end
        end
    end

endmodule
`default_nettype wire

### sv/csr_queue.sv
// Two-entry queue of finished row sums between front and back end.
`default_nettype none
module csr_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire csr_pkg::row_sums_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    empty,
    output csr_pkg::row_sums_t      pop_data
);
    csr_pkg::row_sums_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

### sv/csr_back.sv
// Back end: squared-norm product, integer root, divide and output register.
`default_nettype none
module csr_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [csr_pkg::EPS_W-1:0]     eps,
    input  wire logic                          q_empty,
    input  wire csr_pkg::row_sums_t            q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [csr_pkg::COS_W-1:0]   cosine,
    output csr_pkg::row_sums_t                 sums
);
    localparam int NW = csr_pkg::NORM_W;
    localparam int PW = csr_pkg::PROD_W;
    localparam int QW = csr_pkg::NUM_W;
    localparam int RW = NW + 3;
    localparam logic [5:0] LAST_NB = 6'(NW - 1);
    localparam logic [5:0] LAST_QB = 6'(QW - 1);
    localparam logic [QW-1:0] MAG_MAX = QW'(32768);
    localparam logic [QW-1:0] POS_MAX = QW'(32767);

    typedef enum logic [2:0] {IDLE, MUL, CHK, SQRT, DIV, DONE, HOLD} state_t;

    state_t             state_reg;
    csr_pkg::row_sums_t row_reg;
    logic [5:0]         cnt_reg;
    logic [PW-1:0]      prod_reg;
    logic [NW-1:0]      mb_reg;
    logic [RW-1:0]      rem_reg;
    logic [NW-1:0]      root_reg;
    logic [NW-1:0]      drem_reg;
    logic [QW-1:0]      num_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic signed [csr_pkg::COS_W-1:0] cos_reg;

    logic [RW-1:0] s_rem, s_trial;
    logic [NW:0]   d_r2;
    logic [NW-1:0] dot_mag;

    always_comb begin
        s_rem   = {rem_reg[RW-3:0], prod_reg[PW-1:PW-2]};
        s_trial = {1'b0, root_reg, 2'b01};
        d_r2    = {drem_reg, num_reg[QW-1]};
        dot_mag = row_reg.dot_xy[csr_pkg::DOT_W-1] ? NW'(-row_reg.dot_xy)
                                                    : NW'(row_reg.dot_xy);
    end

    assign q_pop     = (state_reg == IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign cosine    = cos_reg;
    assign sums      = row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (!q_empty) begin
                        row_reg   <= q_data;
                        prod_reg  <= '0;
                        mb_reg    <= q_data.norm_yy;
                        cnt_reg   <= '0;
                        state_reg <= MUL;
                    end
                end
                // Shift-and-add multiply, one bit of norm_yy per cycle.
                MUL: begin
                    prod_reg <= {prod_reg[PW-2:0], 1'b0}
                              + (mb_reg[NW-1] ? {{NW{1'b0}}, row_reg.norm_xx} : '0);
                    mb_reg   <= {mb_reg[NW-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == LAST_NB) begin
                        state_reg <= CHK;
                    end
                end
                CHK: begin
                    neg_reg  <= row_reg.dot_xy[csr_pkg::DOT_W-1];
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                    if (prod_reg < {{(PW-csr_pkg::EPS_W){1'b0}}, eps}) begin
                        cos_reg   <= '0;
                        state_reg <= DONE;
                    end else begin
                        state_reg <= SQRT;
                    end
                end
                // Digit-by-digit square root, two product bits per cycle.
                SQRT: begin
                    prod_reg <= {prod_reg[PW-3:0], 2'b00};
                    if (s_rem >= s_trial) begin
                        rem_reg  <= s_rem - s_trial;
                        root_reg <= {root_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_reg  <= s_rem;
                        root_reg <= {root_reg[NW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == LAST_NB) begin
                        drem_reg  <= '0;
                        num_reg   <= {dot_mag, {(QW-NW){1'b0}}};
                        cnt_reg   <= '0;
                        state_reg <= DIV;
                    end
                end
                // Restoring divide; quotient bits shift into num_reg.
                DIV: begin
                    if (root_reg == '0) begin
                        cos_reg   <= '0;
                        state_reg <= DONE;
                    end else begin
                        if (d_r2 >= {1'b0, root_reg}) begin
                            drem_reg <= NW'(d_r2 - {1'b0, root_reg});
                            num_reg  <= {num_reg[QW-2:0], 1'b1};
                        end else begin
                            drem_reg <= d_r2[NW-1:0];
                            num_reg  <= {num_reg[QW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == LAST_QB) begin
                            state_reg <= HOLD;
                        end
                    end
                end
                HOLD: begin
                    if (neg_reg) begin
                        cos_reg <= (num_reg > MAG_MAX) ? -16'sd32768
                                                       : -$signed(num_reg[15:0]);
                    end else begin
                        cos_reg <= (num_reg > POS_MAX) ? 16'sd32767
                                                       : $signed(num_reg[15:0]);
                    end
                    state_reg <= DONE;
                end
                DONE: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                    end else if (out_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/cosine_similarity_rows_top.sv
// Top level of the streaming row-pair cosine similarity block.
// The block takes one x/y element pair per cycle unless the queue is full, and
// keeps saturating sums of x*y, x*x and y*y; tlast closes a row. Each row yields
// one result transaction with the three sums and the cosine in signed Q1.15,
// zero when norm_xx*norm_yy is below eps_product. The element front end runs at
// one transaction per cycle while the queue has room; finished rows wait in a
// two-entry queue for the back end, whose serial multiply, square root and divide
// set the row cost together with the output handshake. Short rows are therefore
// limited by the back end.
`default_nettype none
module cosine_similarity_rows_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          eps_product_we,
    input  wire logic [63:0]   eps_product_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // x_elem[15:0], y_elem[31:16]
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [143:0]       m_tdata    // cosine, dot_xy, norm_xx, norm_yy, zero pad
);
    logic [csr_pkg::EPS_W-1:0]  eps_reg;
    logic                       q_full, q_empty, q_push, q_pop;
    csr_pkg::row_sums_t         push_data, pop_data, sums;
    logic signed [csr_pkg::COS_W-1:0] cosine;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= 64'd1;
        end else if (eps_product_we) begin
            eps_reg <= eps_product_wdata;
        end
    end

    csr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_elem    (s_tdata[15:0]),
        .y_elem    (s_tdata[31:16]),
        .last_elem (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    csr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    csr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eps       (eps_reg),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cosine    (cosine),
        .sums      (sums)
    );

    assign m_tdata = {4'b0000, sums.norm_yy, sums.norm_xx, sums.dot_xy, cosine};

endmodule
`default_nettype wire

### sv/csr_checker.sv
// Port-level checks for the cosine similarity block, bound to the top level.
`default_nettype none
module csr_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_zero_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[98:58] == 41'd0) |-> m_tdata[15:0] == 16'd0)
        else $error("nonzero cosine for an all-zero x row");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[98] && (m_tdata[97:58] != 40'd0)))
        else $error("norm_xx above its saturation limit");

endmodule

bind cosine_similarity_rows_top csr_checker u_csr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
